/* rtl/cumulative_ack_resend_window_macros.svh */
// Assertion macros used by the resend window top level.
`ifndef CUMULATIVE_ACK_RESEND_WINDOW_MACROS_SVH
`define CUMULATIVE_ACK_RESEND_WINDOW_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CARW_ASSERT_NOW(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CARW_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/carw_pkg.sv */
// Package with the constants, codes and types of the resend window.
package carw_pkg;

   localparam int WINDOW_DEPTH = 32;
   localparam int MAX_RESULTS  = 32;
   localparam int SLOT_W       = $clog2(WINDOW_DEPTH);
   localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);
   localparam int WRAP_W       = SLOT_W + 2;
   localparam int WALK_MAX     = (WINDOW_DEPTH < MAX_RESULTS) ? WINDOW_DEPTH : MAX_RESULTS;
   localparam int ENTRY_W      = 32;

   localparam logic [15:0] LIMIT_RESET = 16'd1024;

   localparam logic [2:0] ACT_SEND     = 3'd0;
   localparam logic [2:0] ACT_ACK      = 3'd1;
   localparam logic [2:0] ACT_QUERY    = 3'd2;
   localparam logic [2:0] ACT_MARK     = 3'd3;
   localparam logic [2:0] ACT_REQ_ACK  = 3'd4;
   localparam logic [2:0] ACT_FLUSH    = 3'd5;
   localparam logic [2:0] ACT_RESET    = 3'd6;

   localparam logic [1:0] KIND_STATUS  = 2'd0;
   localparam logic [1:0] KIND_ENTRY   = 2'd1;
   localparam logic [1:0] KIND_ACK     = 2'd2;

   localparam logic [1:0] STAT_OK      = 2'd0;
   localparam logic [1:0] STAT_FULL    = 2'd1;
   localparam logic [1:0] STAT_ORDER   = 2'd2;

   typedef enum logic {
      ST_IDLE,
      ST_WALK
   } state_type;

endpackage

/* rtl/carw_ram.sv */
// Simple dual-port entry memory with a registered read port.
module carw_ram #(
   parameter int DEPTH = 32,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/cumulative_ack_resend_window.sv */
// Top level of the cumulative-ack resend window with sequencer and result registers.
//
//   Port group   Direction   Handshake
//   req_*        in          start high while busy is low
//   rsp_*        out         rsp_valid for one cycle, no back-pressure
//   csr_*        in          csr_we, taken at once
//
// The result of a control or status item follows in the next cycle.
// A send or flush with entries to list keeps busy high after the transfer while it
// lists them, one entry per cycle from the single entry memory read port, which is
// registered. Reset is synchronous and active high and needs no clearing pass. The
// receiver cannot stall the result channel.
`include "cumulative_ack_resend_window_macros.svh"

module cumulative_ack_resend_window (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_action,
   input  logic [15:0] req_payload_handle,
   input  logic [15:0] req_payload_len,
   input  logic [31:0] req_seq_index,
   output logic        rsp_valid,
   output logic [1:0]  rsp_kind,
   output logic [1:0]  rsp_status,
   output logic        rsp_is_received,
   output logic [31:0] rsp_bundle_first_index,
   output logic [31:0] rsp_ack_index,
   output logic [31:0] rsp_entry_index,
   output logic [15:0] rsp_entry_handle,
   output logic [15:0] rsp_entry_len,
   output logic        rsp_last,
   input  logic        csr_we,
   input  logic [15:0] csr_wdata
);

   carw_pkg::state_type state_ff, state_in;

   logic [31:0]                  last_seq_ff, last_seq_in;
   logic [31:0]                  oldest_ff, oldest_in;
   logic [carw_pkg::CNT_W-1:0]   cnt_ff, cnt_in;
   logic [carw_pkg::SLOT_W-1:0]  head_ff, head_in;
   logic [31:0]                  rcv_ff, rcv_in;
   logic                         ack_due_ff, ack_due_in;
   logic [15:0]                  limit_ff;

   logic [carw_pkg::CNT_W-1:0]   walk_total_ff, walk_total_in;
   logic [carw_pkg::CNT_W-1:0]   rd_cnt_ff, rd_cnt_in;
   logic [carw_pkg::SLOT_W-1:0]  rd_slot_ff, rd_slot_in;
   logic                         rd_vld_ff, rd_vld_in;
   logic [carw_pkg::CNT_W-1:0]   out_cnt_ff, out_cnt_in;
   logic [15:0]                  sum_ff, sum_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  rsp_kind_ff, rsp_kind_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;
   logic        rsp_rcv_ff, rsp_rcv_in;
   logic [31:0] rsp_first_ff, rsp_first_in;
   logic [31:0] rsp_ack_ff, rsp_ack_in;
   logic [31:0] rsp_eidx_ff, rsp_eidx_in;
   logic [15:0] rsp_eh_ff, rsp_eh_in;
   logic [15:0] rsp_el_ff, rsp_el_in;
   logic        rsp_last_ff, rsp_last_in;

   logic                                accept;
   logic                                full;
   logic                                send_ok;
   logic                                issue;
   logic                                walk_stop;
   logic [carw_pkg::WRAP_W-1:0]         wr_wrap;
   logic [carw_pkg::SLOT_W-1:0]         wr_slot;
   logic [31:0]                         ack_off;
   logic                                ack_hit;
   logic [carw_pkg::CNT_W-1:0]          ack_adv;
   logic [carw_pkg::WRAP_W-1:0]         head_wrap;
   logic [carw_pkg::CNT_W-1:0]          cnt_post;
   logic [16:0]                         sum_next;
   logic [carw_pkg::ENTRY_W-1:0]        rd_data;
   logic [carw_pkg::CNT_W-1:0]          out_cnt_inc;

   assign accept  = start && !busy;
   assign full    = (cnt_ff == carw_pkg::CNT_W'(carw_pkg::WINDOW_DEPTH));
   assign send_ok = (req_action == carw_pkg::ACT_SEND) && !full;

   always_comb begin
      wr_wrap = carw_pkg::WRAP_W'(head_ff) + carw_pkg::WRAP_W'(cnt_ff);
      if (wr_wrap >= carw_pkg::WRAP_W'(carw_pkg::WINDOW_DEPTH)) begin
         wr_wrap = wr_wrap - carw_pkg::WRAP_W'(carw_pkg::WINDOW_DEPTH);
      end
      wr_slot = wr_wrap[carw_pkg::SLOT_W-1:0];
   end

   always_comb begin
      ack_off   = req_seq_index - oldest_ff;
      ack_hit   = (ack_off < 32'(cnt_ff));
      ack_adv   = ack_off[carw_pkg::CNT_W-1:0] + carw_pkg::CNT_W'(1);
      head_wrap = carw_pkg::WRAP_W'(head_ff) + carw_pkg::WRAP_W'(ack_adv);
      if (head_wrap >= carw_pkg::WRAP_W'(carw_pkg::WINDOW_DEPTH)) begin
         head_wrap = head_wrap - carw_pkg::WRAP_W'(carw_pkg::WINDOW_DEPTH);
      end
   end

   assign cnt_post    = send_ok ? (cnt_ff + carw_pkg::CNT_W'(1)) : cnt_ff;
   assign sum_next    = {1'b0, sum_ff} + {1'b0, rd_data[15:0]};
   assign out_cnt_inc = out_cnt_ff + carw_pkg::CNT_W'(1);
   assign walk_stop   = (out_cnt_inc == walk_total_ff) || (sum_next > {1'b0, limit_ff});

   carw_ram #(
      .DEPTH (carw_pkg::WINDOW_DEPTH),
      .WIDTH (carw_pkg::ENTRY_W)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (accept && send_ok),
      .wr_addr (wr_slot),
      .wr_data ({req_payload_handle, req_payload_len}),
      .rd_en   (issue),
      .rd_addr (rd_slot_ff),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         carw_pkg::ST_IDLE: begin
            if (accept && (send_ok || (req_action == carw_pkg::ACT_FLUSH)) &&
                (cnt_post != '0)) begin
               state_in = carw_pkg::ST_WALK;
            end
         end
         carw_pkg::ST_WALK: begin
            if (rd_vld_ff && walk_stop) begin
               state_in = carw_pkg::ST_IDLE;
            end
         end
         default: state_in = carw_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      busy  = (state_ff == carw_pkg::ST_WALK);
      issue = (state_ff == carw_pkg::ST_WALK) && (rd_cnt_ff != walk_total_ff);
   end

   always_comb begin
      last_seq_in   = last_seq_ff;
      oldest_in     = oldest_ff;
      cnt_in        = cnt_ff;
      head_in       = head_ff;
      rcv_in        = rcv_ff;
      ack_due_in    = ack_due_ff;
      walk_total_in = walk_total_ff;
      rd_cnt_in     = rd_cnt_ff;
      rd_slot_in    = rd_slot_ff;
      rd_vld_in     = 1'b0;
      out_cnt_in    = out_cnt_ff;
      sum_in        = sum_ff;
      rsp_valid_in  = 1'b0;
      rsp_kind_in   = carw_pkg::KIND_STATUS;
      rsp_status_in = carw_pkg::STAT_OK;
      rsp_rcv_in    = 1'b0;
      rsp_first_in  = '0;
      rsp_ack_in    = '0;
      rsp_eidx_in   = '0;
      rsp_eh_in     = '0;
      rsp_el_in     = '0;
      rsp_last_in   = 1'b1;

      if (accept) begin
         rsp_valid_in  = 1'b1;
         walk_total_in = (cnt_post > carw_pkg::CNT_W'(carw_pkg::WALK_MAX)) ?
                         carw_pkg::CNT_W'(carw_pkg::WALK_MAX) : cnt_post;
         rd_cnt_in     = '0;
         rd_slot_in    = head_ff;
         out_cnt_in    = '0;
         sum_in        = '0;
         unique case (req_action)
            carw_pkg::ACT_SEND, carw_pkg::ACT_FLUSH: begin
               if (req_action == carw_pkg::ACT_SEND && full) begin
                  rsp_status_in = carw_pkg::STAT_FULL;
               end else begin
                  if (send_ok) begin
                     last_seq_in = last_seq_ff + 32'd1;
                     cnt_in      = cnt_post;
                     if (cnt_ff == '0) begin
                        oldest_in = last_seq_ff + 32'd1;
                     end
                  end
                  if (cnt_post != '0) begin
                     ack_due_in   = 1'b0;
                     rsp_valid_in = 1'b0;
                  end else if (ack_due_ff) begin
                     ack_due_in  = 1'b0;
                     rsp_kind_in = carw_pkg::KIND_ACK;
                     rsp_ack_in  = rcv_ff;
                  end
               end
            end
            carw_pkg::ACT_ACK: begin
               if (ack_hit) begin
                  oldest_in = oldest_ff + 32'(ack_adv);
                  head_in   = head_wrap[carw_pkg::SLOT_W-1:0];
                  cnt_in    = cnt_ff - ack_adv;
               end
            end
            carw_pkg::ACT_QUERY: begin
               rsp_rcv_in = (req_seq_index <= rcv_ff);
            end
            carw_pkg::ACT_MARK: begin
               if (req_seq_index == rcv_ff + 32'd1) begin
                  rcv_in = req_seq_index;
               end else begin
                  rsp_status_in = carw_pkg::STAT_ORDER;
               end
            end
            carw_pkg::ACT_REQ_ACK: begin
               ack_due_in = 1'b1;
            end
            carw_pkg::ACT_RESET: begin
               last_seq_in = '0;
               oldest_in   = 32'd1;
               cnt_in      = '0;
               head_in     = '0;
               rcv_in      = '0;
               ack_due_in  = 1'b0;
            end
            default: begin
            end
         endcase
      end else if (state_ff == carw_pkg::ST_WALK) begin
         if (issue) begin
            rd_cnt_in  = rd_cnt_ff + carw_pkg::CNT_W'(1);
            rd_slot_in = (rd_slot_ff == carw_pkg::SLOT_W'(carw_pkg::WINDOW_DEPTH - 1)) ?
                         '0 : rd_slot_ff + carw_pkg::SLOT_W'(1);
            rd_vld_in  = 1'b1;
         end
         if (rd_vld_ff) begin
            rsp_valid_in = 1'b1;
            rsp_kind_in  = carw_pkg::KIND_ENTRY;
            rsp_first_in = oldest_ff;
            rsp_ack_in   = rcv_ff;
            rsp_eidx_in  = oldest_ff + 32'(out_cnt_ff);
            rsp_eh_in    = rd_data[31:16];
            rsp_el_in    = rd_data[15:0];
            rsp_last_in  = walk_stop;
            out_cnt_in   = out_cnt_inc;
            sum_in       = sum_next[15:0];
            if (walk_stop) begin
               rd_vld_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= carw_pkg::ST_IDLE;
         last_seq_ff  <= '0;
         oldest_ff    <= 32'd1;
         cnt_ff       <= '0;
         head_ff      <= '0;
         rcv_ff       <= '0;
         ack_due_ff   <= 1'b0;
         limit_ff     <= carw_pkg::LIMIT_RESET;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         last_seq_ff  <= last_seq_in;
         oldest_ff    <= oldest_in;
         cnt_ff       <= cnt_in;
         head_ff      <= head_in;
         rcv_ff       <= rcv_in;
         ack_due_ff   <= ack_due_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            limit_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      walk_total_ff <= walk_total_in;
      rd_cnt_ff     <= rd_cnt_in;
      rd_slot_ff    <= rd_slot_in;
      out_cnt_ff    <= out_cnt_in;
      sum_ff        <= sum_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_status_ff <= rsp_status_in;
      rsp_rcv_ff    <= rsp_rcv_in;
      rsp_first_ff  <= rsp_first_in;
      rsp_ack_ff    <= rsp_ack_in;
      rsp_eidx_ff   <= rsp_eidx_in;
      rsp_eh_ff     <= rsp_eh_in;
      rsp_el_ff     <= rsp_el_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_kind               = rsp_kind_ff;
   assign rsp_status             = rsp_status_ff;
   assign rsp_is_received        = rsp_rcv_ff;
   assign rsp_bundle_first_index = rsp_first_ff;
   assign rsp_ack_index          = rsp_ack_ff;
   assign rsp_entry_index        = rsp_eidx_ff;
   assign rsp_entry_handle       = rsp_eh_ff;
   assign rsp_entry_len          = rsp_el_ff;
   assign rsp_last               = rsp_last_ff;

   `CARW_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_ff <= carw_pkg::CNT_W'(carw_pkg::WINDOW_DEPTH), "pending count exceeds the window depth")
   `CARW_ASSERT_NOW(a_empty_seq, cnt_ff == '0, oldest_ff == last_seq_ff + 32'd1, "empty window with inconsistent sequence numbers")
   `CARW_ASSERT_NOW(a_walk_pending, state_ff == carw_pkg::ST_WALK, cnt_ff != '0, "bundle walk with no pending entry")
   `CARW_ASSERT_NEXT(a_walk_emit, (state_ff == carw_pkg::ST_WALK) && rd_vld_ff, rsp_valid_ff && (rsp_kind_ff == carw_pkg::KIND_ENTRY), "read data did not produce a bundle entry")
   `CARW_ASSERT_NEXT(a_walk_end, state_ff == carw_pkg::ST_WALK, (state_ff == carw_pkg::ST_WALK) || (rsp_valid_ff && rsp_last_ff), "bundle ended without a final transfer")

endmodule

/* bench/tb.sv */
// Self-checking testbench that drives the resend window and compares each result transfer.
module tb;

   localparam logic [2:0] ACT_UNUSED = 3'd7;

   typedef struct {
      logic [1:0]  kind;
      logic [1:0]  status;
      logic        is_received;
      logic [31:0] first_index;
      logic [31:0] ack_index;
      logic [31:0] entry_index;
      logic [15:0] entry_handle;
      logic [15:0] entry_len;
      logic        is_last;
   } result_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [2:0]  req_action = '0;
   logic [15:0] req_payload_handle = '0;
   logic [15:0] req_payload_len = '0;
   logic [31:0] req_seq_index = '0;
   logic        rsp_valid;
   logic [1:0]  rsp_kind;
   logic [1:0]  rsp_status;
   logic        rsp_is_received;
   logic [31:0] rsp_bundle_first_index;
   logic [31:0] rsp_ack_index;
   logic [31:0] rsp_entry_index;
   logic [15:0] rsp_entry_handle;
   logic [15:0] rsp_entry_len;
   logic        rsp_last;
   logic        csr_we = 1'b0;
   logic [15:0] csr_wdata = '0;

   // Shadow copy of the window, receive side and byte limit.
   logic [15:0] byte_limit = carw_pkg::LIMIT_RESET;
   logic [31:0] last_seq = '0;
   logic [31:0] oldest_seq = 32'd1;
   int unsigned pend_cnt = 0;
   int unsigned head_slot = 0;
   logic [15:0] slot_handle [carw_pkg::WINDOW_DEPTH];
   logic [15:0] slot_len [carw_pkg::WINDOW_DEPTH];
   logic [31:0] rcv_idx = '0;
   logic        ack_owed = 1'b0;

   result_row_type rsp_due [$];
   int             fail_count = 0;
   bit             no_idle = 1'b0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   cumulative_ack_resend_window dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_action(req_action),
      .req_payload_handle(req_payload_handle),
      .req_payload_len(req_payload_len),
      .req_seq_index(req_seq_index),
      .rsp_valid(rsp_valid),
      .rsp_kind(rsp_kind),
      .rsp_status(rsp_status),
      .rsp_is_received(rsp_is_received),
      .rsp_bundle_first_index(rsp_bundle_first_index),
      .rsp_ack_index(rsp_ack_index),
      .rsp_entry_index(rsp_entry_index),
      .rsp_entry_handle(rsp_entry_handle),
      .rsp_entry_len(rsp_entry_len),
      .rsp_last(rsp_last),
      .csr_we(csr_we),
      .csr_wdata(csr_wdata)
   );

   function automatic void push_row(logic [1:0] kind, logic [1:0] status, logic rcv,
                                    logic [31:0] first, logic [31:0] ack,
                                    logic [31:0] eidx, logic [15:0] eh, logic [15:0] el);
      result_row_type row;
      row.kind = kind;
      row.status = status;
      row.is_received = rcv;
      row.first_index = first;
      row.ack_index = ack;
      row.entry_index = eidx;
      row.entry_handle = eh;
      row.entry_len = el;
      row.is_last = 1'b0;
      rsp_due = {rsp_due, row};
   endfunction

   function automatic void clear_session();
      last_seq = '0;
      oldest_seq = 32'd1;
      pend_cnt = 0;
      head_slot = 0;
      rcv_idx = '0;
      ack_owed = 1'b0;
   endfunction

   // A bundle walks pending entries from the oldest and stops at the last one, after
   // MAX_RESULTS entries, or after the entry that pushes the byte total past the limit.
   function automatic void list_bundle();
      int unsigned byte_sum;
      int unsigned i;
      int unsigned slot;
      if (pend_cnt == 0 && !ack_owed) begin
         push_row(carw_pkg::KIND_STATUS, carw_pkg::STAT_OK, 1'b0, '0, '0, '0, '0, '0);
         return;
      end
      ack_owed = 1'b0;
      if (pend_cnt == 0) begin
         push_row(carw_pkg::KIND_ACK, carw_pkg::STAT_OK, 1'b0, '0, rcv_idx, '0, '0, '0);
         return;
      end
      byte_sum = 0;
      for (i = 0; i < pend_cnt && i < carw_pkg::MAX_RESULTS; i++) begin
         slot = (head_slot + i) % carw_pkg::WINDOW_DEPTH;
         push_row(carw_pkg::KIND_ENTRY, carw_pkg::STAT_OK, 1'b0, oldest_seq, rcv_idx,
                  oldest_seq + i, slot_handle[slot], slot_len[slot]);
         byte_sum += slot_len[slot];
         if (byte_sum > byte_limit) break;
      end
   endfunction

   function automatic void predict_window_step(logic [2:0] act, logic [15:0] handle,
                                               logic [15:0] len, logic [31:0] seq);
      logic [31:0] off;
      int unsigned slot;
      case (act)
         carw_pkg::ACT_SEND: begin
            if (pend_cnt >= carw_pkg::WINDOW_DEPTH) begin
               push_row(carw_pkg::KIND_STATUS, carw_pkg::STAT_FULL, 1'b0,
                        '0, '0, '0, '0, '0);
            end else begin
               slot = (head_slot + pend_cnt) % carw_pkg::WINDOW_DEPTH;
               last_seq = last_seq + 32'd1;
               if (pend_cnt == 0) oldest_seq = last_seq;
               slot_handle[slot] = handle;
               slot_len[slot] = len;
               pend_cnt++;
               list_bundle();
            end
         end
         carw_pkg::ACT_ACK: begin
            off = seq - oldest_seq;
            if (off < pend_cnt) begin
               oldest_seq = oldest_seq + off + 32'd1;
               head_slot = (head_slot + off + 1) % carw_pkg::WINDOW_DEPTH;
               pend_cnt = pend_cnt - off - 1;
            end
            push_row(carw_pkg::KIND_STATUS, carw_pkg::STAT_OK, 1'b0, '0, '0, '0, '0, '0);
         end
         carw_pkg::ACT_QUERY: begin
            push_row(carw_pkg::KIND_STATUS, carw_pkg::STAT_OK, seq <= rcv_idx,
                     '0, '0, '0, '0, '0);
         end
         carw_pkg::ACT_MARK: begin
            if (seq == rcv_idx + 32'd1) begin
               rcv_idx = seq;
               push_row(carw_pkg::KIND_STATUS, carw_pkg::STAT_OK, 1'b0,
                        '0, '0, '0, '0, '0);
            end else begin
               push_row(carw_pkg::KIND_STATUS, carw_pkg::STAT_ORDER, 1'b0,
                        '0, '0, '0, '0, '0);
            end
         end
         carw_pkg::ACT_REQ_ACK: begin
            ack_owed = 1'b1;
            push_row(carw_pkg::KIND_STATUS, carw_pkg::STAT_OK, 1'b0, '0, '0, '0, '0, '0);
         end
         carw_pkg::ACT_FLUSH: begin
            list_bundle();
         end
         carw_pkg::ACT_RESET: begin
            clear_session();
            push_row(carw_pkg::KIND_STATUS, carw_pkg::STAT_OK, 1'b0, '0, '0, '0, '0, '0);
         end
         default: begin
            push_row(carw_pkg::KIND_STATUS, carw_pkg::STAT_OK, 1'b0, '0, '0, '0, '0, '0);
         end
      endcase
      rsp_due[rsp_due.size() - 1].is_last = 1'b1;
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s expected %0h actual %0h", name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin : check_results
      result_row_type want;
      if (!reset && rsp_valid) begin
         if (rsp_due.size() == 0) begin
            $error("result transfer with no expected result pending");
            fail_count++;
         end else begin
            want = rsp_due.pop_front();
            check_field("kind", 32'(want.kind), 32'(rsp_kind));
            check_field("status", 32'(want.status), 32'(rsp_status));
            check_field("is_received", 32'(want.is_received), 32'(rsp_is_received));
            check_field("bundle_first_index", want.first_index, rsp_bundle_first_index);
            check_field("ack_index", want.ack_index, rsp_ack_index);
            check_field("entry_index", want.entry_index, rsp_entry_index);
            check_field("entry_handle", 32'(want.entry_handle), 32'(rsp_entry_handle));
            check_field("entry_len", 32'(want.entry_len), 32'(rsp_entry_len));
            check_field("last", 32'(want.is_last), 32'(rsp_last));
         end
      end
   end

   task automatic send_item(logic [2:0] act, logic [15:0] handle, logic [15:0] len,
                            logic [31:0] seq);
      int unsigned gap;
      gap = no_idle ? 0 : $urandom_range(0, 5);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_action <= act;
      req_payload_handle <= handle;
      req_payload_len <= len;
      req_seq_index <= seq;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_window_step(act, handle, len, seq);
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      do @(posedge clock); while (rsp_due.size() != 0 || busy);
   endtask

   task automatic set_byte_limit(logic [15:0] value);
      wait_idle();
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      byte_limit = value;
      csr_we <= 1'b0;
   endtask

   function automatic logic [15:0] pick_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 70) return 16'($urandom_range(0, 400));
      if (r < 90) return 16'($urandom);
      return (r < 95) ? 16'h0000 : 16'hFFFF;
   endfunction

   // Mostly well-formed traffic: acks of pending numbers and in-order marks,
   // with a share of stray numbers and session resets mixed in.
   task automatic run_random_traffic(int unsigned count);
      int unsigned k;
      int unsigned pick;
      logic [2:0]  act;
      logic [15:0] handle;
      logic [15:0] len;
      logic [31:0] seq;
      for (k = 0; k < count; k++) begin
         if (k % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
         pick = $urandom_range(0, 99);
         handle = 16'($urandom);
         len = pick_len();
         seq = 32'($urandom);
         if (pick < 42) begin
            act = carw_pkg::ACT_SEND;
         end else if (pick < 60) begin
            act = carw_pkg::ACT_ACK;
            if (pend_cnt != 0 && $urandom_range(0, 99) < 85)
               seq = oldest_seq + 32'($urandom_range(0, pend_cnt - 1));
            else if ($urandom_range(0, 1) == 0)
               seq = oldest_seq + 32'(pend_cnt) - 32'($urandom_range(0, 1) * (pend_cnt + 1));
         end else if (pick < 68) begin
            act = carw_pkg::ACT_QUERY;
            if ($urandom_range(0, 3) != 0) seq = rcv_idx + 32'($urandom_range(0, 4)) - 32'd2;
         end else if (pick < 79) begin
            act = carw_pkg::ACT_MARK;
            if ($urandom_range(0, 9) < 8) seq = rcv_idx + 32'd1;
         end else if (pick < 85) begin
            act = carw_pkg::ACT_REQ_ACK;
         end else if (pick < 95) begin
            act = carw_pkg::ACT_FLUSH;
         end else if (pick < 97) begin
            act = carw_pkg::ACT_RESET;
         end else begin
            act = ACT_UNUSED;
         end
         send_item(act, handle, len, seq);
      end
      no_idle = 1'b0;
   endtask

   task automatic test_receive_tracking();
      send_item(carw_pkg::ACT_QUERY, 16'h0000, 16'h0000, 32'h0000_0000);
      send_item(carw_pkg::ACT_QUERY, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
      send_item(carw_pkg::ACT_MARK, 16'h0000, 16'h0000, 32'd5);
      send_item(carw_pkg::ACT_MARK, 16'h0000, 16'h0000, 32'd1);
      send_item(carw_pkg::ACT_QUERY, 16'h0000, 16'h0000, 32'd1);
      send_item(carw_pkg::ACT_QUERY, 16'h0000, 16'h0000, 32'd2);
      send_item(carw_pkg::ACT_MARK, 16'h0000, 16'h0000, 32'd0);
   endtask

   task automatic test_ack_bundles();
      send_item(carw_pkg::ACT_FLUSH, 16'h0000, 16'h0000, 32'h0);
      send_item(ACT_UNUSED, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
      send_item(carw_pkg::ACT_REQ_ACK, 16'h0000, 16'h0000, 32'h0);
      send_item(carw_pkg::ACT_FLUSH, 16'h0000, 16'h0000, 32'h0);
      send_item(carw_pkg::ACT_FLUSH, 16'h0000, 16'h0000, 32'h0);
      send_item(carw_pkg::ACT_REQ_ACK, 16'h0000, 16'h0000, 32'h0);
   endtask

   task automatic test_send_and_ack();
      send_item(carw_pkg::ACT_SEND, 16'hFFFF, 16'h0000, 32'h0);
      send_item(carw_pkg::ACT_SEND, 16'h0000, 16'hFFFF, 32'h0);
      send_item(carw_pkg::ACT_SEND, 16'h1234, 16'd10, 32'h0);
      send_item(carw_pkg::ACT_ACK, 16'h0000, 16'h0000, 32'hFFFF_FFFF);
      send_item(carw_pkg::ACT_ACK, 16'h0000, 16'h0000, 32'h0000_0000);
      send_item(carw_pkg::ACT_ACK, 16'h0000, 16'h0000, 32'd2);
      send_item(carw_pkg::ACT_FLUSH, 16'h0000, 16'h0000, 32'h0);
      send_item(carw_pkg::ACT_ACK, 16'h0000, 16'h0000, 32'd3);
      send_item(carw_pkg::ACT_FLUSH, 16'h0000, 16'h0000, 32'h0);
   endtask

   task automatic test_session_reset();
      send_item(carw_pkg::ACT_SEND, 16'hA5A5, 16'd100, 32'h0);
      send_item(carw_pkg::ACT_REQ_ACK, 16'h0000, 16'h0000, 32'h0);
      send_item(carw_pkg::ACT_RESET, 16'h0000, 16'h0000, 32'h0);
      send_item(carw_pkg::ACT_FLUSH, 16'h0000, 16'h0000, 32'h0);
      send_item(carw_pkg::ACT_QUERY, 16'h0000, 16'h0000, 32'h0);
   endtask

   task automatic test_window_full();
      int unsigned k;
      set_byte_limit(16'hFFFF);
      send_item(carw_pkg::ACT_RESET, 16'h0000, 16'h0000, 32'h0);
      for (k = 0; k <= carw_pkg::WINDOW_DEPTH; k++) begin
         send_item(carw_pkg::ACT_SEND, 16'($urandom), 16'($urandom_range(0, 1500)),
                   32'($urandom));
      end
      send_item(carw_pkg::ACT_ACK, 16'h0000, 16'h0000, oldest_seq + 32'd15);
      send_item(carw_pkg::ACT_SEND, 16'($urandom), 16'($urandom_range(0, 1500)), 32'h0);
      send_item(carw_pkg::ACT_FLUSH, 16'h0000, 16'h0000, 32'h0);
      send_item(carw_pkg::ACT_ACK, 16'h0000, 16'h0000, last_seq);
   endtask

   task automatic test_byte_limit_extremes();
      set_byte_limit(16'h0000);
      send_item(carw_pkg::ACT_SEND, 16'h0001, 16'h0000, 32'h0);
      send_item(carw_pkg::ACT_SEND, 16'h0002, 16'h0000, 32'h0);
      send_item(carw_pkg::ACT_SEND, 16'h0003, 16'h0001, 32'h0);
      send_item(carw_pkg::ACT_SEND, 16'h0004, 16'h0000, 32'h0);
      run_random_traffic(50);
      set_byte_limit(16'hFFFF);
      send_item(carw_pkg::ACT_SEND, 16'h0005, 16'hFFFF, 32'h0);
      send_item(carw_pkg::ACT_FLUSH, 16'h0000, 16'h0000, 32'h0);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_receive_tracking();
      test_ack_bundles();
      test_send_and_ack();
      test_session_reset();
      test_window_full();
      test_byte_limit_extremes();
      run_random_traffic(110);
      set_byte_limit(carw_pkg::LIMIT_RESET);
      run_random_traffic(100);
      set_byte_limit(16'($urandom_range(1, 65534)));
      run_random_traffic(30);
      wait_idle();
      repeat (40) @(posedge clock);
      if (fail_count == 0) begin
         $display("cumulative_ack_resend_window: match");
      end else begin
         $display("cumulative_ack_resend_window: mismatch");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("cumulative_ack_resend_window: mismatch");
      $finish;
   end

endmodule

/* cumulative_ack_resend_window.f */
+incdir+rtl
rtl/carw_pkg.sv
rtl/carw_ram.sv
rtl/cumulative_ack_resend_window.sv
bench/tb.sv
